// ===== hdl/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_STR     = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX1    = 4'd3,
        MODE_WAIT_BS = 4'd4,
        MODE_WAIT_U  = 4'd5,
        MODE_HEX2    = 4'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_MISS_QUOTE    = 3'd1,
        ST_BAD_ESCAPE    = 3'd2,
        ST_BAD_CHAR      = 3'd3,
        ST_BAD_HEX       = 3'd4,
        ST_BAD_SURROGATE = 3'd5
    } status_t;

    // Everything one input word leaves behind for the output side.
    typedef struct packed {
        logic            has_res;
        logic            is_end;
        status_t         status;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/json_string_unescape_utf8_unit.sv =====
// JSON string unescaper with UTF-8 output.
// Input channel: one byte of JSON text per word on ch, taken when in_valid and
// in_ready are both high. Bytes before an opening quote are dropped.
// Output channel: one result word per handshake on out_valid/out_ready. A data
// word carries a decoded byte (byte_valid set); an end word has string_done set
// and the status (ok on a closing quote, otherwise the error found). The last
// flag marks the final word caused by one input byte.
// Latency: results of a byte appear in the cycle after it is taken.
// Throughput: one input byte per cycle while the receiver takes every word
// and each byte gives at most one result; a byte that completes a \u escape
// gives one to four words, and the input is held off until the last of them leaves.
// in_ready depends combinationally on out_ready: the buffer accepts a new byte
// in the same cycle as its last word leaves.
// Reset returns the decoder to waiting for an opening quote and empties the
// result buffer. When the receiver stalls, the current word holds steady and
// the input is held off once the buffer is full.
`default_nettype none

module json_string_unescape_utf8_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            string_done,
    output logic [2:0]      status,
    output logic            last
);

    logic             in_fire;
    jsu_pkg::result_t res;

    assign in_fire = in_valid && in_ready;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .ch      (ch),
        .res     (res)
    );

    jsu_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .res         (res),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .status      (status),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== hdl/jsu_decode.sv =====
`default_nettype none

module jsu_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic [7:0]        ch,
    output jsu_pkg::result_t       res
);

    localparam logic [7:0]  CH_QUOTE = 8'h22;
    localparam logic [7:0]  CH_BSL   = 8'h5C;
    localparam logic [7:0]  CH_U     = 8'h75;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [15:0] HI_MIN   = 16'hD800;
    localparam logic [15:0] HI_MAX   = 16'hDBFF;
    localparam logic [15:0] LO_MIN   = 16'hDC00;
    localparam logic [15:0] LO_MAX   = 16'hDFFF;
    localparam logic [20:0] SUP_BASE = 21'h10000;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } enc_t;

    function automatic enc_t utf8_encode(input logic [20:0] u);
        enc_t e;
        e = '0;
        if (u <= 21'h7F) begin
            e.bytes[0] = u[7:0];
            e.last_idx = 2'd0;
        end else if (u <= 21'h7FF) begin
            e.bytes[0] = {3'b110, u[10:6]};
            e.bytes[1] = {2'b10, u[5:0]};
            e.last_idx = 2'd1;
        end else if (u <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, u[15:12]};
            e.bytes[1] = {2'b10, u[11:6]};
            e.bytes[2] = {2'b10, u[5:0]};
            e.last_idx = 2'd2;
        end else begin
            e.bytes[0] = {5'b11110, u[20:18]};
            e.bytes[1] = {2'b10, u[17:12]};
            e.bytes[2] = {2'b10, u[11:6]};
            e.bytes[3] = {2'b10, u[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_count_reg, hex_count_next;
    logic [15:0]    hex_value_reg, hex_value_next;
    logic [9:0]     high_sur_reg, high_sur_next;

    logic        dig_ok;
    logic [3:0]  dig;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [15:0] hv;
    logic        hex_full;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp_pair;
    enc_t        enc_first;
    enc_t        enc_pair;

    always_comb
    begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            dig = ch[3:0];
        end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            dig = ch[3:0] + 4'd9;
        end else begin
            dig_ok = 1'b0;
        end
    end

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = 8'h00;
        unique case (ch)
            8'h22:   esc_byte = 8'h22;
            8'h5C:   esc_byte = 8'h5C;
            8'h2F:   esc_byte = 8'h2F;
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            default: esc_ok = 1'b0;
        endcase
    end

    assign hv        = {hex_value_reg[11:0], dig};
    assign hex_full  = (hex_count_reg == 2'd3);
    assign is_high   = (hv >= HI_MIN) && (hv <= HI_MAX);
    assign is_low    = (hv >= LO_MIN) && (hv <= LO_MAX);
    assign cp_pair   = {1'b0, high_sur_reg, hv[9:0]} + SUP_BASE;
    assign enc_first = utf8_encode({5'd0, hv});
    assign enc_pair  = utf8_encode(cp_pair);

    // Next state.
    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        hex_value_next = hex_value_reg;
        high_sur_next  = high_sur_reg;
        unique case (mode_reg)
            jsu_pkg::MODE_STR:
            begin
                if (ch == CH_BSL) begin
                    mode_next = jsu_pkg::MODE_ESC;
                end else if (ch < CH_SPACE || ch == CH_QUOTE) begin
                    mode_next      = jsu_pkg::MODE_IDLE;
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                hex_count_next = 2'd0;
                hex_value_next = 16'd0;
                if (ch == CH_U) begin
                    mode_next = jsu_pkg::MODE_HEX1;
                end else if (esc_ok) begin
                    mode_next = jsu_pkg::MODE_STR;
                end else begin
                    mode_next = jsu_pkg::MODE_IDLE;
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2:
            begin
                if (!dig_ok) begin
                    mode_next      = jsu_pkg::MODE_IDLE;
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                end else if (!hex_full) begin
                    hex_count_next = hex_count_reg + 2'd1;
                    hex_value_next = hv;
                end else begin
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                    if (mode_reg == jsu_pkg::MODE_HEX1) begin
                        if (is_high) begin
                            high_sur_next = hv[9:0];
                            mode_next     = jsu_pkg::MODE_WAIT_BS;
                        end else begin
                            mode_next = jsu_pkg::MODE_STR;
                        end
                    end else begin
                        mode_next = is_low ? jsu_pkg::MODE_STR : jsu_pkg::MODE_IDLE;
                    end
                end
            end
            jsu_pkg::MODE_WAIT_BS:
            begin
                if (ch == CH_BSL) begin
                    mode_next = jsu_pkg::MODE_WAIT_U;
                end else begin
                    mode_next      = jsu_pkg::MODE_IDLE;
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                end
            end
            jsu_pkg::MODE_WAIT_U:
            begin
                hex_count_next = 2'd0;
                hex_value_next = 16'd0;
                mode_next = (ch == CH_U) ? jsu_pkg::MODE_HEX2 : jsu_pkg::MODE_IDLE;
            end
            default:
            begin
                mode_next = jsu_pkg::MODE_IDLE;
                if (ch == CH_QUOTE) begin
                    mode_next      = jsu_pkg::MODE_STR;
                    hex_count_next = 2'd0;
                    hex_value_next = 16'd0;
                end
            end
        endcase
    end

    // Results for the current word.
    always_comb
    begin
        res = '0;
        res.status = jsu_pkg::ST_OK;
        unique case (mode_reg)
            jsu_pkg::MODE_STR:
            begin
                if (ch == CH_QUOTE) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                end else if (ch == CH_BSL) begin
                    res.has_res = 1'b0;
                end else if (ch == 8'h00) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_MISS_QUOTE;
                end else if (ch < CH_SPACE) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_BAD_CHAR;
                end else begin
                    res.has_res  = 1'b1;
                    res.bytes[0] = ch;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                if (ch != CH_U) begin
                    res.has_res = 1'b1;
                    if (esc_ok) begin
                        res.bytes[0] = esc_byte;
                    end else begin
                        res.is_end = 1'b1;
                        res.status = jsu_pkg::ST_BAD_ESCAPE;
                    end
                end
            end
            jsu_pkg::MODE_HEX1:
            begin
                if (!dig_ok) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_BAD_HEX;
                end else if (hex_full && !is_high) begin
                    res.has_res  = 1'b1;
                    res.bytes    = enc_first.bytes;
                    res.last_idx = enc_first.last_idx;
                end
            end
            jsu_pkg::MODE_HEX2:
            begin
                if (!dig_ok) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_BAD_HEX;
                end else if (hex_full) begin
                    res.has_res = 1'b1;
                    if (is_low) begin
                        res.bytes    = enc_pair.bytes;
                        res.last_idx = enc_pair.last_idx;
                    end else begin
                        res.is_end = 1'b1;
                        res.status = jsu_pkg::ST_BAD_SURROGATE;
                    end
                end
            end
            jsu_pkg::MODE_WAIT_BS:
            begin
                if (ch != CH_BSL) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_BAD_SURROGATE;
                end
            end
            jsu_pkg::MODE_WAIT_U:
            begin
                if (ch != CH_U) begin
                    res.has_res = 1'b1;
                    res.is_end  = 1'b1;
                    res.status  = jsu_pkg::ST_BAD_SURROGATE;
                end
            end
            default:
            begin
                res.has_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= jsu_pkg::MODE_IDLE;
            hex_count_reg <= 2'd0;
            hex_value_reg <= 16'd0;
            high_sur_reg  <= 10'd0;
        end else if (in_fire) begin
            mode_reg      <= mode_next;
            hex_count_reg <= hex_count_next;
            hex_value_reg <= hex_value_next;
            high_sur_reg  <= high_sur_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_emit.sv =====
`default_nettype none

module jsu_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  jsu_pkg::result_t       res,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   byte_valid,
    output logic                   string_done,
    output logic [2:0]             status,
    output logic                   last
);

    logic             full_reg;
    logic [1:0]       idx_reg;
    jsu_pkg::result_t buf_reg;
    logic             at_last;
    logic             out_fire;

    assign at_last   = (idx_reg == buf_reg.last_idx);
    assign out_fire  = full_reg && out_ready;
    // The buffer takes a new word as soon as its final result leaves.
    assign in_ready  = !full_reg || (out_ready && at_last);

    assign out_valid   = full_reg;
    assign out_byte    = buf_reg.is_end ? 8'h00 : buf_reg.bytes[idx_reg];
    assign byte_valid  = !buf_reg.is_end;
    assign string_done = buf_reg.is_end;
    assign status      = buf_reg.is_end ? buf_reg.status : jsu_pkg::ST_OK;
    assign last        = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (in_fire && res.has_res) begin
            full_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (out_fire && at_last) begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (out_fire) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res.has_res) begin
            buf_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/jsu_checker.sv =====
`default_nettype none

module jsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] ch,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       string_done,
    input wire logic [2:0] status,
    input wire logic       last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(ch))
        else $error("input word changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output word changed while stalled");

    // An end word is always alone and the final word of its input byte.
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> last && !byte_valid && out_byte == 8'h00)
        else $error("malformed end word");

    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !string_done && status == jsu_pkg::ST_OK)
        else $error("data word carries an end status");

    // Only one buffered result set exists, so nothing is taken mid-sequence.
    a_no_take_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input taken while results still pending");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .string_done (string_done),
    .status      (status),
    .last        (last)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam int ITEM_TARGET = 410;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [7:0]       data;
        logic             is_byte;
        logic             is_end;
        jsu_pkg::status_t code;
        logic             fin;
    } out_word_t;

    typedef struct packed {
        logic       pause;
        logic [7:0] val;
    } feed_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] ch = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
    logic       last;

    json_string_unescape_utf8_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .string_done (string_done),
        .status      (status),
        .last        (last)
    );

    always #5 clk = ~clk;

    feed_t     text_q[$];
    out_word_t decoded_q[$];
    int        n_items = 0;
    int        mismatches = 0;
    int        seen = 0;
    int        gap_left = 0;
    int        quiet_in = 0;
    int        stall_left = 0;
    int        quiet_out = 0;
    bit        long_hold_done = 1'b0;
    int        dead_cycles = 0;

    // Decoder state as the block should hold it.
    jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
    logic [1:0]     hex_n = 2'd0;
    logic [15:0]    hex_acc = 16'h0000;
    logic [9:0]     hi_half = 10'h000;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, c[3:0]};
        if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    // Bit 8 set when the byte names a simple escape; bits 7:0 give its value.
    function automatic logic [8:0] escape_code(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return {1'b1, CH_QUOTE};
            CH_BSLASH: return {1'b1, CH_BSLASH};
            "/":       return {1'b1, 8'h2F};
            "b":       return {1'b1, 8'h08};
            "f":       return {1'b1, 8'h0C};
            "n":       return {1'b1, 8'h0A};
            "r":       return {1'b1, 8'h0D};
            "t":       return {1'b1, 8'h09};
            default:   return 9'h000;
        endcase
    endfunction

    function automatic out_word_t mk_word(input logic [7:0] b, input logic is_b,
                                          input logic is_e, input jsu_pkg::status_t s);
        out_word_t w;
        w.data    = b;
        w.is_byte = is_b;
        w.is_end  = is_e;
        w.code    = s;
        w.fin     = 1'b0;
        return w;
    endfunction

    function automatic int idle_cycles(inout int quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if (r == 0) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        decoded_q.insert(decoded_q.size(), mk_word(b, 1'b1, 1'b0, jsu_pkg::ST_OK));
    endtask

    task automatic end_string(input jsu_pkg::status_t s);
        dec_mode = jsu_pkg::MODE_IDLE;
        hex_n    = 2'd0;
        hex_acc  = 16'h0000;
        decoded_q.insert(decoded_q.size(), mk_word(8'h00, 1'b0, 1'b1, s));
    endtask

    task automatic emit_utf8(input logic [20:0] u);
        if (u <= 21'h7F) begin
            emit_byte(u[7:0]);
        end
        else if (u <= 21'h7FF) begin
            emit_byte({3'b110, u[10:6]});
            emit_byte({2'b10, u[5:0]});
        end
        else if (u <= 21'hFFFF) begin
            emit_byte({4'b1110, u[15:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end
        else begin
            emit_byte({5'b11110, u[20:18]});
            emit_byte({2'b10, u[17:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end
    endtask

    task automatic take_hex(input logic [7:0] c, input bit second);
        logic [4:0]  d;
        logic [15:0] u;
        d = hex_val(c);
        if (d[4]) begin
            end_string(jsu_pkg::ST_BAD_HEX);
            return;
        end
        hex_acc = {hex_acc[11:0], d[3:0]};
        if (hex_n != 2'd3) begin
            hex_n = hex_n + 2'd1;
            return;
        end
        u       = hex_acc;
        hex_n   = 2'd0;
        hex_acc = 16'h0000;
        if (!second) begin
            if (u >= 16'hD800 && u <= 16'hDBFF) begin
                hi_half  = u[9:0];
                dec_mode = jsu_pkg::MODE_WAIT_BS;
                return;
            end
            dec_mode = jsu_pkg::MODE_STR;
            emit_utf8({5'd0, u});
            return;
        end
        if (u < 16'hDC00 || u > 16'hDFFF) begin
            end_string(jsu_pkg::ST_BAD_SURROGATE);
            return;
        end
        dec_mode = jsu_pkg::MODE_STR;
        emit_utf8(21'h10000 + {1'b0, hi_half, u[9:0]});
    endtask

    // Works out the words one accepted text byte should produce.
    task automatic unescape_byte(input logic [7:0] c);
        int         start;
        logic [8:0] esc;
        out_word_t  tail;
        start = decoded_q.size();
        case (dec_mode)
            jsu_pkg::MODE_STR: begin
                if (c == CH_QUOTE)
                    end_string(jsu_pkg::ST_OK);
                else if (c == CH_BSLASH)
                    dec_mode = jsu_pkg::MODE_ESC;
                else if (c == 8'h00)
                    end_string(jsu_pkg::ST_MISS_QUOTE);
                else if (c < 8'h20)
                    end_string(jsu_pkg::ST_BAD_CHAR);
                else
                    emit_byte(c);
            end
            jsu_pkg::MODE_ESC: begin
                esc = escape_code(c);
                if (c == CH_U) begin
                    dec_mode = jsu_pkg::MODE_HEX1;
                    hex_n    = 2'd0;
                    hex_acc  = 16'h0000;
                end
                else if (!esc[8]) begin
                    end_string(jsu_pkg::ST_BAD_ESCAPE);
                end
                else begin
                    dec_mode = jsu_pkg::MODE_STR;
                    emit_byte(esc[7:0]);
                end
            end
            jsu_pkg::MODE_HEX1: take_hex(c, 1'b0);
            jsu_pkg::MODE_HEX2: take_hex(c, 1'b1);
            jsu_pkg::MODE_WAIT_BS: begin
                if (c == CH_BSLASH)
                    dec_mode = jsu_pkg::MODE_WAIT_U;
                else
                    end_string(jsu_pkg::ST_BAD_SURROGATE);
            end
            jsu_pkg::MODE_WAIT_U: begin
                if (c == CH_U) begin
                    dec_mode = jsu_pkg::MODE_HEX2;
                    hex_n    = 2'd0;
                    hex_acc  = 16'h0000;
                end
                else begin
                    end_string(jsu_pkg::ST_BAD_SURROGATE);
                end
            end
            default: begin
                dec_mode = jsu_pkg::MODE_IDLE;
                if (c == CH_QUOTE) begin
                    dec_mode = jsu_pkg::MODE_STR;
                    hex_n    = 2'd0;
                    hex_acc  = 16'h0000;
                end
            end
        endcase
        if (decoded_q.size() > start) begin
            tail = decoded_q[decoded_q.size() - 1];
            tail.fin = 1'b1;
            decoded_q[decoded_q.size() - 1] = tail;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at word %0d: %s", seen, what);
    endtask

    task automatic check_word;
        out_word_t want;
        if (decoded_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected word, byte %h done %b", out_byte, string_done));
            return;
        end
        want = decoded_q.pop_front();
        if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %h, wanted %h", out_byte, want.data));
        if (byte_valid !== want.is_byte)
            flag_mismatch($sformatf("byte_valid %b, wanted %b", byte_valid, want.is_byte));
        if (string_done !== want.is_end)
            flag_mismatch($sformatf("string_done %b, wanted %b", string_done, want.is_end));
        if (status !== want.code)
            flag_mismatch($sformatf("status %0d, wanted %0d", status, want.code));
        if (last !== want.fin)
            flag_mismatch($sformatf("last %b, wanted %b", last, want.fin));
    endtask

    // Stimulus building.
    task automatic add(input logic [7:0] b);
        feed_t f;
        f.pause = 1'b0;
        f.val   = b;
        text_q.insert(text_q.size(), f);
        n_items++;
    endtask

    task automatic add_noise(input logic [7:0] b);
        feed_t f;
        f.pause = 1'b0;
        f.val   = b;
        text_q.insert(text_q.size(), f);
    endtask

    task automatic add_pause;
        feed_t f;
        f.pause = 1'b1;
        f.val   = 8'h00;
        text_q.insert(text_q.size(), f);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    task automatic add_u(input logic [15:0] v);
        add(CH_BSLASH);
        add(CH_U);
        add(hex_char(v[15:12]));
        add(hex_char(v[11:8]));
        add(hex_char(v[7:4]));
        add(hex_char(v[3:0]));
    endtask

    // Any code point that is not a high surrogate, boundaries included.
    function automatic logic [15:0] rand_bmp;
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            3: return 16'($urandom_range(16'hE000, 16'hFFFF));
            4: return 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_high;
        case ($urandom_range(0, 3))
            0: return 16'hD800;
            1: return 16'hDBFF;
            default: return 16'($urandom_range(16'hD800, 16'hDBFF));
        endcase
    endfunction

    function automatic logic [15:0] rand_low;
        case ($urandom_range(0, 3))
            0: return 16'hDC00;
            1: return 16'hDFFF;
            default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
    endfunction

    task automatic add_segment;
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                b = 8'($urandom_range(8'h20, 8'hFF));
                while (b == CH_QUOTE || b == CH_BSLASH)
                    b = 8'($urandom_range(8'h20, 8'hFF));
                add(b);
            end
            4, 5: begin
                add(CH_BSLASH);
                case ($urandom_range(0, 7))
                    0: add(CH_QUOTE);
                    1: add(CH_BSLASH);
                    2: add("/");
                    3: add("b");
                    4: add("f");
                    5: add("n");
                    6: add("r");
                    default: add("t");
                endcase
            end
            6, 7, 8: add_u(rand_bmp());
            default: begin
                add_u(rand_high());
                add_u(rand_low());
            end
        endcase
    endtask

    task automatic add_error_end;
        logic [7:0]  b;
        logic [15:0] v;
        logic [4:0]  d;
        case ($urandom_range(0, 5))
            0: add(8'h00);
            1: add(8'($urandom_range(8'h01, 8'h1F)));
            2: begin
                add(CH_BSLASH);
                b = 8'($urandom_range(0, 255));
                while (escape_code(b) != 9'h000 || b == CH_U)
                    b = 8'($urandom_range(0, 255));
                add(b);
            end
            3: begin
                if ($urandom_range(0, 1))
                    add_u(rand_high());
                add(CH_BSLASH);
                add(CH_U);
                repeat ($urandom_range(0, 3))
                    add(hex_char(4'($urandom_range(0, 15))));
                b = 8'($urandom_range(0, 255));
                d = hex_val(b);
                while (!d[4]) begin
                    b = 8'($urandom_range(0, 255));
                    d = hex_val(b);
                end
                add(b);
            end
            default: begin
                add_u(rand_high());
                case ($urandom_range(0, 2))
                    0: begin
                        b = 8'($urandom_range(0, 255));
                        while (b == CH_BSLASH)
                            b = 8'($urandom_range(0, 255));
                        add(b);
                    end
                    1: begin
                        add(CH_BSLASH);
                        b = 8'($urandom_range(0, 255));
                        while (b == CH_U)
                            b = 8'($urandom_range(0, 255));
                        add(b);
                    end
                    default: begin
                        if ($urandom_range(0, 1))
                            v = 16'($urandom_range(16'h0000, 16'hDBFF));
                        else
                            v = 16'($urandom_range(16'hE000, 16'hFFFF));
                        add_u(v);
                    end
                endcase
            end
        endcase
    endtask

    // One string: maybe some dropped bytes, the opening quote, a body, and an end.
    task automatic add_string;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE)
                    b = 8'($urandom_range(0, 255));
                add_noise(b);
            end
        end
        add(CH_QUOTE);
        repeat ($urandom_range(0, 10))
            add_segment();
        if ($urandom_range(0, 19) < 14)
            add(CH_QUOTE);
        else
            add_error_end();
    endtask

    always @(posedge clk or negedge rst_n) begin : drive
        feed_t head;
        if (!rst_n) begin
            in_valid <= 1'b0;
            ch       <= 8'h00;
            gap_left = 0;
            quiet_in = 0;
        end
        else begin
            if (in_valid && in_ready)
                unescape_byte(ch);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() == 0) begin
                    in_valid <= 1'b0;
                end
                else begin
                    head = text_q.pop_front();
                    if (!head.pause) begin
                        in_valid <= 1'b1;
                        ch       <= head.val;
                        gap_left = idle_cycles(quiet_in);
                    end
                    else begin
                        // Hold the marker until every expected word has come back.
                        in_valid <= 1'b0;
                        if (decoded_q.size() != 0)
                            text_q.push_front(head);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
            quiet_out  = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                check_word();
                seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!long_hold_done && seen >= 100 && in_valid) begin
                // A long hold with the sender still busy fills the result buffer.
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else begin
                stall_left = idle_cycles(quiet_out);
                out_ready <= (stall_left == 0);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        // Directed opening: dropped bytes, extremes, escapes and every error end but a bad surrogate.
        add_noise(8'h00);
        add_noise("A");
        add(CH_QUOTE);
        add(8'hFF);
        add(8'h20);
        add(CH_BSLASH);
        add("n");
        add_u(16'h0000);
        add(CH_QUOTE);
        add(CH_QUOTE);
        add(8'h1F);
        add(CH_QUOTE);
        add(8'h00);
        add(CH_QUOTE);
        add(CH_BSLASH);
        add("q");
        add(CH_QUOTE);
        add(CH_BSLASH);
        add(CH_U);
        add("G");
        add_pause();

        while (n_items < ITEM_TARGET) begin
            add_string();
            if (n_items >= 200 && n_items < 240)
                add_pause();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (decoded_q.size() != 0)
            flag_mismatch($sformatf("%0d expected words never arrived", decoded_q.size()));
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
